@@ hw/rtl/uapq_pkg.sv @@
`default_nettype none

package uapq_pkg;

  // Operation code carried on the input channel
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_REMOVED  = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    insert;      // append input pair at the tail, count up
    logic    start_scan;  // rewind the read pointer for a search
    logic    scan;        // one search step
    logic    shift;       // one compaction step
    logic    retire;      // count down after a removal
    logic    set_res;     // latch the pending result status
    status_t res_code;
    logic    emit;        // move the pending result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;   // last held entry is being compared this cycle
    logic shift_done;  // compaction finished
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/uapq_ram.sv @@
`default_nettype none

// Generic single write port, single read port RAM with registered read
module uapq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hw/rtl/uapq_ctrl.sv @@
`default_nettype none

module uapq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  output logic                    in_ready,
  input  wire uapq_pkg::dp_stat_t stat,
  output uapq_pkg::dp_cmd_t       cmd
);

  uapq_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= uapq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    cmd.res_code = uapq_pkg::ST_INSERTED;
    unique case (state_r)
      uapq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == uapq_pkg::OP_INSERT) begin
            cmd.set_res = 1'b1;
            state_nxt   = uapq_pkg::S_RESULT;
            if (stat.full) begin
              cmd.res_code = uapq_pkg::ST_FULL;
            end else begin
              cmd.insert   = 1'b1;
              cmd.res_code = uapq_pkg::ST_INSERTED;
            end
          end else if (stat.empty) begin
            cmd.set_res  = 1'b1;
            cmd.res_code = uapq_pkg::ST_EMPTY;
            state_nxt    = uapq_pkg::S_RESULT;
          end else begin
            cmd.start_scan = 1'b1;
            state_nxt      = uapq_pkg::S_SCAN;
          end
        end
      end
      uapq_pkg::S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = uapq_pkg::S_SHIFT;
        end
      end
      uapq_pkg::S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          cmd.retire   = 1'b1;
          cmd.set_res  = 1'b1;
          cmd.res_code = uapq_pkg::ST_REMOVED;
          state_nxt    = uapq_pkg::S_RESULT;
        end
      end
      uapq_pkg::S_RESULT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = uapq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = uapq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/uapq_dp.sv @@
`default_nettype none

module uapq_dp #(
  parameter int CAPACITY  = 16,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [PRIO_BITS-1:0] in_priority_req,
  input  wire logic [DATA_BITS-1:0] in_payload,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [PRIO_BITS-1:0]      out_priority,
  output logic [DATA_BITS-1:0]      out_payload,
  output logic [CNT_W-1:0]          out_fill_count,
  input  wire uapq_pkg::dp_cmd_t    cmd,
  output uapq_pkg::dp_stat_t        stat
);

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = PRIO_BITS + DATA_BITS;

  // Entry store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     addr_r, addr_nxt;     // next read pointer
  logic                 dv_r, dv_nxt;         // read data arriving this cycle
  logic [CNT_W-1:0]     didx_r, didx_nxt;     // index of arriving data
  logic [CNT_W-1:0]     best_idx_r, best_idx_nxt;
  logic [PRIO_BITS-1:0] best_p_r, best_p_nxt;
  logic [DATA_BITS-1:0] best_d_r, best_d_nxt;
  uapq_pkg::status_t    res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [PRIO_BITS-1:0] out_priority_r, out_priority_nxt;
  logic [DATA_BITS-1:0] out_payload_r, out_payload_nxt;
  logic [CNT_W-1:0]     out_fill_r, out_fill_nxt;

  logic [PRIO_BITS-1:0] rd_p;
  logic [DATA_BITS-1:0] rd_d;
  logic                 issue;
  logic                 take;
  logic [CNT_W-1:0]     best_idx_eff;

  uapq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_p  = ram_rdata[EW-1:DATA_BITS];
  assign rd_d  = ram_rdata[DATA_BITS-1:0];
  assign issue = (addr_r < cnt_r);

  // Earliest maximum wins: replace only on a strictly larger priority
  assign take         = dv_r && ((didx_r == '0) || (rd_p > best_p_r));
  assign best_idx_eff = take ? didx_r : best_idx_r;

  // Status towards the controller
  always_comb begin
    stat.full       = (cnt_r == CNT_W'(CAPACITY));
    stat.empty      = (cnt_r == '0);
    stat.scan_last  = dv_r && (didx_r == (cnt_r - CNT_W'(1)));
    stat.shift_done = !issue && !dv_r;
    stat.out_free   = !out_valid_r || out_ready;
  end

  // Next-state logic of the datapath
  always_comb begin
    cnt_nxt          = cnt_r;
    addr_nxt         = addr_r;
    dv_nxt           = dv_r;
    didx_nxt         = didx_r;
    best_idx_nxt     = best_idx_r;
    best_p_nxt       = best_p_r;
    best_d_nxt       = best_d_r;
    res_status_nxt   = res_status_r;
    out_valid_nxt    = out_valid_r;
    out_status_nxt   = out_status_r;
    out_priority_nxt = out_priority_r;
    out_payload_nxt  = out_payload_r;
    out_fill_nxt     = out_fill_r;
    ram_we           = 1'b0;
    ram_waddr        = cnt_r[AW-1:0];
    ram_wdata        = {in_priority_req, in_payload};

    // Append at the tail
    if (cmd.insert) begin
      ram_we  = 1'b1;
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cmd.start_scan) begin
      addr_nxt = '0;
      dv_nxt   = 1'b0;
    end

    // Search: stream every held entry, keep the running maximum
    if (cmd.scan) begin
      dv_nxt   = issue;
      didx_nxt = addr_r;
      if (issue) begin
        addr_nxt = addr_r + CNT_W'(1);
      end
      if (take) begin
        best_idx_nxt = didx_r;
        best_p_nxt   = rd_p;
        best_d_nxt   = rd_d;
      end
      if (stat.scan_last) begin
        addr_nxt = best_idx_eff + CNT_W'(1);
        dv_nxt   = 1'b0;
      end
    end

    // Compaction: read entry i+1 and write it to i
    if (cmd.shift) begin
      dv_nxt   = issue;
      didx_nxt = addr_r;
      if (issue) begin
        addr_nxt = addr_r + CNT_W'(1);
      end
      if (dv_r) begin
        ram_we    = 1'b1;
        ram_waddr = AW'(didx_r - CNT_W'(1));
        ram_wdata = ram_rdata;
      end
    end

    if (cmd.retire) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    // Pending result; only a removal carries an entry
    if (cmd.set_res) begin
      res_status_nxt = cmd.res_code;
      if (cmd.res_code != uapq_pkg::ST_REMOVED) begin
        best_p_nxt = '0;
        best_d_nxt = '0;
      end
    end

    // Output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt    = 1'b1;
      out_status_nxt   = res_status_r;
      out_priority_nxt = best_p_r;
      out_payload_nxt  = best_d_r;
      out_fill_nxt     = cnt_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and pointer registers
  always_ff @(posedge clk) begin
    addr_r         <= addr_nxt;
    didx_r         <= didx_nxt;
    best_idx_r     <= best_idx_nxt;
    best_p_r       <= best_p_nxt;
    best_d_r       <= best_d_nxt;
    res_status_r   <= res_status_nxt;
    out_status_r   <= out_status_nxt;
    out_priority_r <= out_priority_nxt;
    out_payload_r  <= out_payload_nxt;
    out_fill_r     <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_priority   = out_priority_r;
  assign out_payload    = out_payload_r;
  assign out_fill_count = out_fill_r;

endmodule

`default_nettype wire

@@ hw/rtl/unsorted_array_priority_queue.sv @@
// Bounded priority queue over an unsorted entry store.
// Input channel (in_valid/in_ready): in_op selects insert or remove; an insert
// carries in_priority_req and in_payload. Every input transfer gives exactly one
// result transfer on the output channel (out_valid/out_ready): out_status
// (inserted, full, removed, empty), the removed pair on out_priority and
// out_payload (zero otherwise) and out_fill_count, the entries held afterwards.
// Removal returns the largest priority, the earliest entry on ties.
// An insert, a full insert or an empty remove goes straight to its result; a
// remove of entry b out of n held entries first makes one read of the store's
// single read port per entry for the search, then one read and write per later
// entry to close the gap. One item in flight at a time.
// in_ready is high only while the block is idle; the next item is accepted
// while a finished result still sits in the output register.
// If the receiver stalls, the result holds in the output register and the block
// waits before emitting the next one.
// Synchronous reset empties the queue; store contents are not cleared.
`default_nettype none

module unsorted_array_priority_queue #(
  parameter int CAPACITY  = 16,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_op,
  input  wire logic [PRIO_BITS-1:0] in_priority_req,
  input  wire logic [DATA_BITS-1:0] in_payload,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                out_status,
  output logic [PRIO_BITS-1:0]      out_priority,
  output logic [DATA_BITS-1:0]      out_payload,
  output logic [CNT_W-1:0]          out_fill_count
);

  uapq_pkg::dp_cmd_t  cmd;
  uapq_pkg::dp_stat_t stat;

  // Sequencer
  uapq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, search and output register
  uapq_dp #(
    .CAPACITY  (CAPACITY),
    .PRIO_BITS (PRIO_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_priority_req (in_priority_req),
    .in_payload      (in_payload),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_priority    (out_priority),
    .out_payload     (out_payload),
    .out_fill_count  (out_fill_count),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

`default_nettype wire

@@ hw/rtl/uapq_checker.sv @@
`default_nettype none

module uapq_assertions #(
  parameter int CAPACITY  = 16,
  parameter int PRIO_BITS = 8,
  parameter int DATA_BITS = 16,
  localparam int CNT_W = $clog2(CAPACITY + 1)
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [1:0]           out_status,
  input wire logic [PRIO_BITS-1:0] out_priority,
  input wire logic [DATA_BITS-1:0] out_payload,
  input wire logic [CNT_W-1:0]     out_fill_count
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_priority) && $stable(out_payload) && $stable(out_fill_count))
    else $error("result changed while stalled");

  // One item in flight: no back-to-back input transfers
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // Only a removal carries an entry
  a_zero_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != 2'(uapq_pkg::ST_REMOVED)) |->
      (out_priority == '0) && (out_payload == '0))
    else $error("non-removal result carries an entry");

  // Empty remove reports an empty queue
  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 2'(uapq_pkg::ST_EMPTY)) |-> out_fill_count == '0)
    else $error("empty result with nonzero fill count");

  // Dropped insert reports a full queue
  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 2'(uapq_pkg::ST_FULL)) |->
      out_fill_count == CNT_W'(CAPACITY))
    else $error("full result without full fill count");

endmodule

bind unsorted_array_priority_queue uapq_assertions #(
  .CAPACITY  (CAPACITY),
  .PRIO_BITS (PRIO_BITS),
  .DATA_BITS (DATA_BITS)
) u_uapq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_priority   (out_priority),
  .out_payload    (out_payload),
  .out_fill_count (out_fill_count)
);

`default_nettype wire
